// ===== sv/pee_pkg.sv =====
// Package for the postfix expression evaluator: word width, character codes,
// status and operation codes, controller states and the control/status structs.
// No dependencies; every module of the block imports it (the interfaces do not).
package pee_pkg;

  localparam int WORD_W          = 32;
  localparam int STACK_DEPTH_DEF = 16;

  // ASCII codes of the accepted characters
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_ADD  = 8'h2B;
  localparam logic [7:0] CH_SUB  = 8'h2D;
  localparam logic [7:0] CH_MUL  = 8'h2A;
  localparam logic [7:0] CH_DIV  = 8'h2F;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_UNDER   = 3'd2,
    ST_OVER    = 3'd3,
    ST_DIVZERO = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    OP_DIGIT,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_BAD
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_POP_RHS,
    S_POP_LHS,
    S_OPER,
    S_EXEC,
    S_DIV_WAIT,
    S_PUSH,
    S_END,
    S_LAST_POP,
    S_EMIT
  } ctrl_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_in;     // capture the accepted request
    logic push_digit;  // push the digit value
    logic push_res;    // push the operation result
    logic pop;         // pop the top into the read register
    logic cap_rhs;     // latch the popped word as right operand
    logic cap_lhs;     // latch the popped word as left operand
    logic exec;        // compute add, sub, mul or zero-divisor result
    logic div_start;   // launch the divider
    logic div_take;    // latch the divider quotient
    logic mark_bad;    // record an invalid character
    logic emit;        // load the output register and clear the expression
  } pee_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    op_t  op;
    logic aborted;
    logic last;
    logic rhs_zero;
    logic div_done;
    logic out_busy;
  } pee_sts_t;

  // Classify one character of the expression
  function automatic op_t decode_char(input logic [7:0] ch);
    op_t op;
    priority if (ch >= CH_ZERO && ch <= CH_NINE) op = OP_DIGIT;
    else if (ch == CH_ADD)                       op = OP_ADD;
    else if (ch == CH_SUB)                       op = OP_SUB;
    else if (ch == CH_MUL)                       op = OP_MUL;
    else if (ch == CH_DIV)                       op = OP_DIV;
    else                                         op = OP_BAD;
    return op;
  endfunction

endpackage

// ===== sv/pee_if.sv =====
// Valid/ready channel interfaces of the postfix expression evaluator:
// the character request channel and the result channel.
// Field widths are fixed; no package dependency.
interface pee_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

interface pee_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic        [2:0]  status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

// ===== sv/pee_div.sv =====
// Bit-serial signed divider, truncating toward zero, one quotient bit a cycle.
// Depends on pee_pkg for the word width.
module pee_div
  import pee_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [WORD_W-1:0] dividend,
  input  logic [WORD_W-1:0] divisor,
  output logic              done,
  output logic [WORD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(WORD_W);

  logic              busy_r,  busy_nxt;
  logic              done_r,  done_nxt;
  logic [CNT_W-1:0]  cnt_r,   cnt_nxt;
  logic [WORD_W-1:0] rem_r,   rem_nxt;
  logic [WORD_W-1:0] quo_r,   quo_nxt;
  logic [WORD_W-1:0] den_r,   den_nxt;
  logic              neg_r,   neg_nxt;
  logic [WORD_W:0]   rem_sh;
  logic [WORD_W:0]   diff;

  // Load the operands on start, else shift in one dividend bit and try a subtract
  always_comb begin
    rem_sh   = {rem_r, quo_r[WORD_W-1]};
    diff     = rem_sh - {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend[WORD_W-1] ? (~dividend + 1'b1) : dividend;
      den_nxt  = divisor[WORD_W-1]  ? (~divisor + 1'b1)  : divisor;
      neg_nxt  = dividend[WORD_W-1] ^ divisor[WORD_W-1];
    end else if (busy_r) begin
      if (!diff[WORD_W]) begin
        rem_nxt = diff[WORD_W-1:0];
        quo_nxt = {quo_r[WORD_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[WORD_W-1:0];
        quo_nxt = {quo_r[WORD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(WORD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Hold control state under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? (~quo_r + 1'b1) : quo_r;

endmodule

// ===== sv/pee_datapath.sv =====
// Datapath of the postfix expression evaluator: operand stack memory, count,
// error tracking, operand and result registers, divider and output register.
// Depends on pee_pkg and pee_div; driven by commands from pee_ctrl.
module pee_datapath
  import pee_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        in_character,
  input  logic              in_last,
  input  pee_cmd_t          cmd,
  output pee_sts_t          sts,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [WORD_W-1:0] out_value,
  output logic [2:0]        out_status
);

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);

  logic [WORD_W-1:0] stack_mem [STACK_DEPTH];

  logic [7:0]        ch_r;
  logic              last_r;
  logic [CNT_W-1:0]  count_r,  count_nxt;
  status_t           first_error_r, first_error_nxt;
  logic              aborted_r, aborted_nxt;
  logic              rd_hit_r, rd_hit_nxt;
  logic [WORD_W-1:0] rd_data_r;
  logic [WORD_W-1:0] lhs_r, rhs_r, result_r;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_value_r;
  status_t           out_status_r;

  logic [CNT_W-1:0]  cnt_dec;
  status_t           err_note;
  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [WORD_W-1:0] wr_data;
  logic [WORD_W-1:0] digit_val;
  logic [WORD_W-1:0] popped;
  logic [WORD_W-1:0] div_q;
  logic              div_done;
  op_t               op;

  assign op        = decode_char(ch_r);
  assign digit_val = WORD_W'(4'(ch_r - CH_ZERO));
  assign cnt_dec   = count_r - 1'b1;
  assign popped    = rd_hit_r ? rd_data_r : '0;

  // Stack pointer, memory access and first-error tracking
  always_comb begin
    count_nxt   = count_r;
    err_note    = ST_OK;
    wr_en       = 1'b0;
    wr_addr     = count_r[ADDR_W-1:0];
    wr_data     = cmd.push_digit ? digit_val : result_r;
    rd_en       = 1'b0;
    rd_addr     = cnt_dec[ADDR_W-1:0];
    rd_hit_nxt  = rd_hit_r;
    aborted_nxt = aborted_r;
    if (cmd.push_digit || cmd.push_res) begin
      if (count_r < CNT_W'(STACK_DEPTH)) begin
        wr_en     = 1'b1;
        count_nxt = count_r + 1'b1;
      end else begin
        err_note  = ST_OVER;
      end
    end
    if (cmd.pop) begin
      rd_hit_nxt = (count_r != '0);
      if (count_r != '0) begin
        rd_en     = 1'b1;
        count_nxt = cnt_dec;
      end else begin
        err_note  = ST_UNDER;
      end
    end
    if (cmd.exec && op == OP_DIV && rhs_r == '0) begin
      err_note = ST_DIVZERO;
    end
    if (cmd.mark_bad) begin
      err_note    = ST_INVALID;
      aborted_nxt = 1'b1;
    end
    if (first_error_r == ST_OK && err_note != ST_OK) first_error_nxt = err_note;
    else                                             first_error_nxt = first_error_r;
    // Clear the expression once its result is loaded
    if (cmd.emit) begin
      count_nxt       = '0;
      first_error_nxt = ST_OK;
      aborted_nxt     = 1'b0;
    end
  end

  // Output register: hold until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit)          out_valid_nxt = 1'b1;
    else if (out_ready)    out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r       <= '0;
      first_error_r <= ST_OK;
      aborted_r     <= 1'b0;
      rd_hit_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      count_r       <= count_nxt;
      first_error_r <= first_error_nxt;
      aborted_r     <= aborted_nxt;
      rd_hit_r      <= rd_hit_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Stack memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) stack_mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= stack_mem[rd_addr];
  end

  // Request, operand, result and output payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      ch_r   <= in_character;
      last_r <= in_last;
    end
    if (cmd.cap_rhs) rhs_r <= popped;
    if (cmd.cap_lhs) lhs_r <= popped;
    if (cmd.exec) begin
      unique case (op)
        OP_ADD:  result_r <= lhs_r + rhs_r;
        OP_SUB:  result_r <= lhs_r - rhs_r;
        OP_MUL:  result_r <= lhs_r * rhs_r;
        default: result_r <= '0;
      endcase
    end else if (cmd.div_take) begin
      result_r <= div_q;
    end
    if (cmd.emit) begin
      out_value_r  <= aborted_r ? '1 : popped;
      out_status_r <= first_error_r;
    end
  end

  pee_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (lhs_r),
    .divisor  (rhs_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    sts.op       = op;
    sts.aborted  = aborted_r;
    sts.last     = last_r;
    sts.rhs_zero = (rhs_r == '0);
    sts.div_done = div_done;
    sts.out_busy = out_valid_r && !out_ready;
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (count_r == '0) && (first_error_r == ST_OK) && !aborted_r)
    else $error("expression state not cleared after result");

  a_abort_err: assert property (@(posedge clk) disable iff (!rst_n)
    aborted_r |-> (first_error_r != ST_OK))
    else $error("aborted expression without a recorded error");

  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !(out_valid_r && !out_ready))
    else $error("result loaded over an untaken result");
`endif

endmodule

// ===== sv/pee_ctrl.sv =====
// Controller state machine of the postfix expression evaluator: sequences
// decode, pops, operation, push and the final pop. Depends on pee_pkg.
module pee_ctrl
  import pee_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  pee_sts_t sts,
  output pee_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (sts.aborted) begin
          state_nxt = S_END;
        end else if (sts.op == OP_DIGIT) begin
          cmd.push_digit = 1'b1;
          state_nxt      = S_END;
        end else begin
          state_nxt = S_POP_RHS;
        end
      end
      S_POP_RHS: begin
        cmd.pop   = 1'b1;
        state_nxt = S_POP_LHS;
      end
      S_POP_LHS: begin
        cmd.cap_rhs = 1'b1;
        cmd.pop     = 1'b1;
        state_nxt   = S_OPER;
      end
      S_OPER: begin
        cmd.cap_lhs = 1'b1;
        state_nxt   = S_EXEC;
      end
      S_EXEC: begin
        priority if (sts.op == OP_BAD) begin
          cmd.mark_bad = 1'b1;
          state_nxt    = S_END;
        end else if (sts.op == OP_DIV && !sts.rhs_zero) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV_WAIT;
        end else begin
          cmd.exec  = 1'b1;
          state_nxt = S_PUSH;
        end
      end
      S_DIV_WAIT: begin
        if (sts.div_done) begin
          cmd.div_take = 1'b1;
          state_nxt    = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.push_res = 1'b1;
        state_nxt    = S_END;
      end
      S_END: begin
        state_nxt = sts.last ? S_LAST_POP : S_IDLE;
      end
      S_LAST_POP: begin
        cmd.pop   = !sts.aborted;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

`ifndef SYNTH
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> (state_r == S_DIV_WAIT))
    else $error("divider launched without waiting for it");

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (cmd.pop == 1'b0) && (cmd.emit == 1'b0))
    else $error("request taken while an item is in work");

  a_emit_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> $past(state_r == S_LAST_POP) || $past(state_r == S_EMIT))
    else $error("result emitted outside the final pop");
`endif

endmodule

// ===== sv/postfix_expression_evaluator.sv =====
// Postfix expression evaluator: takes one ASCII character per request and
// evaluates on a stack of 32-bit signed words; the request marked last yields
// one result (popped top, or -1 after an invalid character) with the first
// error code. The controller handles one character at a time: a digit is
// decoded and pushed; + - * / pop the right and then the left operand, then
// compute and push the result, / by a bit-serial divider at one bit per cycle
// (skipped when the divisor is zero); an invalid character goes through the
// pops and aborts, and characters after it are only decoded. The last
// character adds the final pop and the output load, plus any wait for the
// previous result to be taken. The stack sits in a memory with one write
// and one registered read port. The output register holds a result until
// taken while new characters of the next expression are accepted.
module postfix_expression_evaluator
  import pee_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
  input  logic             clk,
  input  logic             rst_n,
  pee_in_if.sink           in_chan,
  pee_out_if.source        out_chan
);

  pee_cmd_t          cmd;
  pee_sts_t          sts;
  logic [WORD_W-1:0] value_w;
  logic [2:0]        status_w;

  pee_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pee_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_character (in_chan.character),
    .in_last      (in_chan.last),
    .cmd          (cmd),
    .sts          (sts),
    .out_ready    (out_chan.ready),
    .out_valid    (out_chan.valid),
    .out_value    (value_w),
    .out_status   (status_w)
  );

  assign out_chan.value  = $signed(value_w);
  assign out_chan.status = status_w;

endmodule
